FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

FILE: src/ttlepc_pkg.sv
// ---------------------------------------------------------------------------
// ttlepc_pkg
// Types and constants of the TTL entry pool compactor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttlepc_pkg;

   localparam int LIFE_W    = 16;
   localparam int AGE_W     = 32;
   localparam int NEW_AGE_W = 16;
   localparam int PAYLOAD_W = 64;
   localparam int STEP_W    = 16;
   localparam int SLOT_W    = 9;
   localparam int LIVE_W    = 10;
   localparam int OPCODE_W  = 2;

   // request word layout, lowest bit first
   localparam int REQ_TDATA_W  = 128;
   localparam int REQ_LIFE_LO  = 0;
   localparam int REQ_AGE_LO   = REQ_LIFE_LO + LIFE_W;
   localparam int REQ_PAY_LO   = REQ_AGE_LO + NEW_AGE_W;
   localparam int REQ_STEP_LO  = REQ_PAY_LO + PAYLOAD_W;
   localparam int REQ_SLOT_LO  = REQ_STEP_LO + STEP_W;

   // response word layout
   localparam int RSP_TDATA_W = 128;
   localparam int RSP_USED_W  = 1 + LIVE_W + 1 + LIFE_W + AGE_W + PAYLOAD_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_AGE    = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_AGE  = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [AGE_W-1:0]     age;
      logic [LIFE_W-1:0]    life;
   } entry_type;

endpackage

FILE: src/ttl_entry_pool_compactor.sv
// An insert or no-op passes from IDLE to DONE, a read through READ and an age pass
// through AGE before DONE loads the response register; DONE holds while it is full.
// One request is in flight at a time; the next word is taken the cycle after the
// response register loads. The age pass streams the pool through the dual-port
// entry memory, one entry read per cycle and each survivor rewritten. Reset clears the
// control state and the live count; pool memory keeps its contents.
// ---------------------------------------------------------------------------
// ttl_entry_pool_compactor
// Entry pool with insert, read and in-order aging with compaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttl_entry_pool_compactor #(
   parameter int POOL_DEPTH = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // new_life, new_age, new_payload, age_step, read_slot, zero pad
   input  logic [ttlepc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic [ttlepc_pkg::OPCODE_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // accepted, live_count, slot_valid, life_out, age_out, payload_out, zero pad
   output logic [ttlepc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ttlepc_pkg::*;

   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int SLOT_CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int LIVE_EXT_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);

   // request fields
   opcode_type           req_opcode;
   logic [LIFE_W-1:0]    req_new_life;
   logic [NEW_AGE_W-1:0] req_new_age;
   logic [PAYLOAD_W-1:0] req_new_payload;
   logic [STEP_W-1:0]    req_age_step;
   logic [SLOT_W-1:0]    req_read_slot;

   assign req_opcode      = opcode_type'(req_tuser);
   assign req_new_life    = req_tdata[REQ_LIFE_LO +: LIFE_W];
   assign req_new_age     = req_tdata[REQ_AGE_LO +: NEW_AGE_W];
   assign req_new_payload = req_tdata[REQ_PAY_LO +: PAYLOAD_W];
   assign req_age_step    = req_tdata[REQ_STEP_LO +: STEP_W];
   assign req_read_slot   = req_tdata[REQ_SLOT_LO +: SLOT_W];

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       wr_ff, wr_in;
   logic                   inflight_ff, inflight_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   res_accepted_ff, res_accepted_in;
   logic                   res_valid_ff, res_valid_in;
   entry_type              res_entry_ff, res_entry_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // entry memory
   entry_type              entry_mem_ff [POOL_DEPTH];
   entry_type              rd_data_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   entry_type              mem_wd;
   logic                   mem_re;
   logic [IDX_W-1:0]       mem_ra;

   logic [SLOT_CMP_W-1:0]  slot_ext;
   logic [SLOT_CMP_W-1:0]  count_ext;
   logic [LIVE_EXT_W-1:0]  live_ext;
   logic [AGE_W:0]         age_sum;
   entry_type              aged;

   assign slot_ext  = SLOT_CMP_W'(req_read_slot);
   assign count_ext = SLOT_CMP_W'(count_ff);
   assign live_ext  = LIVE_EXT_W'(count_ff);

   // saturating age update of the entry coming out of memory
   assign age_sum      = {1'b0, rd_data_ff.age} + (AGE_W + 1)'(step_ff);
   assign aged.payload = rd_data_ff.payload;
   assign aged.life    = rd_data_ff.life - step_ff;
   assign aged.age     = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rd_in           = rd_ff;
      wr_in           = wr_ff;
      inflight_in     = inflight_ff;
      step_in         = step_ff;
      res_accepted_in = res_accepted_ff;
      res_valid_in    = res_valid_ff;
      res_entry_in    = res_entry_ff;
      rsp_vld_in      = rsp_vld_ff;
      rsp_data_in     = rsp_data_ff;
      mem_we          = 1'b0;
      mem_wa          = '0;
      mem_wd          = '0;
      mem_re          = 1'b0;
      mem_ra          = '0;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_accepted_in = 1'b0;
               res_valid_in    = 1'b0;
               res_entry_in    = '0;
               case (req_opcode)
                  OP_INSERT: begin
                     if (count_ff < DEPTH_C) begin
                        mem_we          = 1'b1;
                        mem_wa          = count_ff[IDX_W-1:0];
                        mem_wd.payload  = req_new_payload;
                        mem_wd.age      = AGE_W'(req_new_age);
                        mem_wd.life     = req_new_life;
                        count_in        = count_ff + CNT_W'(1);
                        res_accepted_in = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  OP_AGE: begin
                     step_in     = req_age_step;
                     rd_in       = '0;
                     wr_in       = '0;
                     inflight_in = 1'b0;
                     state_in    = ST_AGE;
                  end
                  OP_READ: begin
                     if (slot_ext < count_ext) begin
                        res_valid_in = 1'b1;
                        mem_re       = 1'b1;
                        mem_ra       = slot_ext[IDX_W-1:0];
                     end
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_AGE: begin
            // issue the next read while the previous entry is written back
            inflight_in = 1'b0;
            if (rd_ff < count_ff) begin
               mem_re      = 1'b1;
               mem_ra      = rd_ff[IDX_W-1:0];
               rd_in       = rd_ff + CNT_W'(1);
               inflight_in = 1'b1;
            end
            if (inflight_ff) begin
               // survivors move down to the write pointer, drop the rest
               if (rd_data_ff.life >= step_ff) begin
                  mem_we = 1'b1;
                  mem_wa = wr_ff[IDX_W-1:0];
                  mem_wd = aged;
                  wr_in  = wr_ff + CNT_W'(1);
               end
            end else if (rd_ff >= count_ff) begin
               count_in = wr_ff;
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            if (res_valid_ff) begin
               res_entry_in = rd_data_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {{RSP_PAD_W{1'b0}}, res_entry_ff.payload, res_entry_ff.age,
                              res_entry_ff.life, res_valid_ff, live_ext[LIVE_W-1:0],
                              res_accepted_ff};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         inflight_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         inflight_ff <= inflight_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff           <= rd_in;
      wr_ff           <= wr_in;
      step_ff         <= step_in;
      res_accepted_ff <= res_accepted_in;
      res_valid_ff    <= res_valid_in;
      res_entry_ff    <= res_entry_in;
      rsp_data_ff     <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem_ff[mem_ra];
      end
   end

   `ASSERT_NEVER(a_count_in_range, clock, reset, count_ff > DEPTH_C, "live count above pool depth")
   `ASSERT_NEVER(a_wr_behind_rd, clock, reset, (state_ff == ST_AGE) && (wr_ff > rd_ff), "compaction write pointer passed read pointer")
   `ASSERT_CLK(a_count_held_in_pass, clock, reset, (state_ff == ST_AGE) && (state_in == ST_AGE) |=> $stable(count_ff), "live count changed during age pass")
   `ASSERT_CLK(a_full_insert_dropped, clock, reset, req_tvalid && req_tready && (req_opcode == OP_INSERT) && (count_ff == DEPTH_C) |=> (count_ff == DEPTH_C), "insert into full pool changed count")

endmodule

FILE: tb/sv/ttl_entry_pool_compactor_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttl_entry_pool_compactor_tb
// Self-checking bench for the TTL entry pool compactor. A short directed
// table covers empty-pool operations, field extremes, out-of-range reads
// and the survival boundary. Random phases follow: fill to capacity, mixed
// churn with aging passes, then back-to-back traffic. Every response word
// is checked field by field against the directed table or an in-bench model of the pool.
// ---------------------------------------------------------------------------
module ttl_entry_pool_compactor_tb;
   import ttlepc_pkg::*;

   localparam int POOL_DEPTH      = 512;
   localparam int CLOCK_HALF      = 2;
   localparam int RESET_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int MAX_REPORTS     = 10;
   localparam int FILL_LIMIT      = 800;
   localparam int CHURN_END       = 1020;
   localparam int TOTAL_ITEMS     = 1170;

   localparam logic [AGE_W-1:0]     AGE_MAX  = '1;
   localparam logic [PAYLOAD_W-1:0] PAY_ONES = '1;

   // response word layout, lowest bit first
   localparam int RSP_LIVE_LO  = 1;
   localparam int RSP_VALID_LO = RSP_LIVE_LO + LIVE_W;
   localparam int RSP_LIFE_LO  = RSP_VALID_LO + 1;
   localparam int RSP_AGE_LO   = RSP_LIFE_LO + LIFE_W;
   localparam int RSP_PAY_LO   = RSP_AGE_LO + AGE_W;

   typedef struct packed {
      opcode_type           op;
      logic [LIFE_W-1:0]    life;
      logic [NEW_AGE_W-1:0] age;
      logic [PAYLOAD_W-1:0] payload;
      logic [STEP_W-1:0]    step;
      logic [SLOT_W-1:0]    slot;
   } pool_req_type;

   typedef struct packed {
      logic                 accepted;
      logic [LIVE_W-1:0]    live;
      logic                 slot_valid;
      logic [LIFE_W-1:0]    life;
      logic [AGE_W-1:0]     age;
      logic [PAYLOAD_W-1:0] payload;
   } pool_rsp_type;

   typedef struct packed {
      pool_req_type req;
      logic         known;
      pool_rsp_type rsp;
   } table_row_type;

   localparam pool_rsp_type NO_RSP = '0;
   localparam int DIRECTED_ROWS = 22;

   // rows with known set carry their response; the rest go through the model
   localparam table_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd0}, 1'b1,
        '{1'b0, 10'd0, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_NOP, 16'hffff, 16'hffff, PAY_ONES, 16'hffff, 9'd511}, 1'b1,
        '{1'b0, 10'd0, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_AGE, 16'h0, 16'h0, 64'h0, 16'h0, 9'd0}, 1'b1,
        '{1'b0, 10'd0, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_AGE, 16'h0, 16'h0, 64'h0, 16'hffff, 9'd0}, 1'b1,
        '{1'b0, 10'd0, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_INSERT, 16'hffff, 16'hffff, PAY_ONES, 16'h0, 9'd0}, 1'b1,
        '{1'b1, 10'd1, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_INSERT, 16'h0, 16'h0, 64'h0, 16'hffff, 9'd511}, 1'b1,
        '{1'b1, 10'd2, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd0}, 1'b1,
        '{1'b0, 10'd2, 1'b1, 16'hffff, 32'h0000_ffff, PAY_ONES}},
      '{'{OP_READ, 16'hffff, 16'hffff, PAY_ONES, 16'hffff, 9'd1}, 1'b1,
        '{1'b0, 10'd2, 1'b1, 16'h0, 32'h0, 64'h0}},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd2}, 1'b1,
        '{1'b0, 10'd2, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd511}, 1'b1,
        '{1'b0, 10'd2, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_INSERT, 16'd100, 16'd7, 64'h0123_4567_89ab_cdef, 16'h0, 9'd0}, 1'b1,
        '{1'b1, 10'd3, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_INSERT, 16'd50, 16'd1, 64'ha5a5_a5a5_5a5a_5a5a, 16'h0, 9'd0}, 1'b1,
        '{1'b1, 10'd4, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_AGE, 16'h0, 16'h0, 64'h0, 16'd0, 9'd0}, 1'b1,
        '{1'b0, 10'd4, 1'b0, 16'h0, 32'h0, 64'h0}},
      // life 0 drops, life 50 survives at zero
      '{'{OP_AGE, 16'h0, 16'h0, 64'h0, 16'd50, 9'd0}, 1'b1,
        '{1'b0, 10'd3, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd0}, 1'b0, NO_RSP},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd1}, 1'b0, NO_RSP},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd2}, 1'b0, NO_RSP},
      '{'{OP_AGE, 16'h0, 16'h0, 64'h0, 16'd1, 9'd0}, 1'b1,
        '{1'b0, 10'd2, 1'b0, 16'h0, 32'h0, 64'h0}},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd1}, 1'b0, NO_RSP},
      '{'{OP_INSERT, 16'hffff, 16'h0, 64'h8000_0000_0000_0001, 16'h1234, 9'h0aa},
        1'b0, NO_RSP},
      '{'{OP_AGE, 16'h0, 16'h0, 64'h0, 16'hffff, 9'd0}, 1'b0, NO_RSP},
      '{'{OP_READ, 16'h0, 16'h0, 64'h0, 16'h0, 9'd0}, 1'b0, NO_RSP}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OPCODE_W-1:0]    req_tuser  = OP_NOP;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // pool model
   logic [LIFE_W-1:0]    pool_life    [POOL_DEPTH];
   logic [AGE_W-1:0]     pool_age     [POOL_DEPTH];
   logic [PAYLOAD_W-1:0] pool_payload [POOL_DEPTH];
   int                   pool_count = 0;

   pool_rsp_type pending_rsps [$];
   int           mismatch_count = 0;
   int           items_sent     = 0;
   int           idle_cycles    = 0;
   bit           gaps_on        = 1'b1;
   bit           hold_off_req   = 1'b0;

   ttl_entry_pool_compactor #(
      .POOL_DEPTH(POOL_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic pool_rsp_type apply_to_pool(pool_req_type r);
      pool_rsp_type o;
      int           kept;
      o = '0;
      kept = 0;
      case (r.op)
         OP_INSERT: begin
            if (pool_count < POOL_DEPTH) begin
               pool_life[pool_count]    = r.life;
               pool_age[pool_count]     = AGE_W'(r.age);
               pool_payload[pool_count] = r.payload;
               pool_count++;
               o.accepted = 1'b1;
            end
         end
         OP_AGE: begin
            // slide survivors down over dropped entries, keep their order
            for (int i = 0; i < pool_count; i++) begin
               if (pool_life[i] >= r.step) begin
                  pool_life[kept] = pool_life[i] - r.step;
                  pool_age[kept]  = (AGE_MAX - pool_age[i] < AGE_W'(r.step)) ? AGE_MAX
                                    : pool_age[i] + AGE_W'(r.step);
                  pool_payload[kept] = pool_payload[i];
                  kept++;
               end
            end
            pool_count = kept;
         end
         OP_READ: begin
            if (int'(r.slot) < pool_count) begin
               o.slot_valid = 1'b1;
               o.life       = pool_life[r.slot];
               o.age        = pool_age[r.slot];
               o.payload    = pool_payload[r.slot];
            end
         end
         default: ;
      endcase
      o.live = LIVE_W'(pool_count);
      return o;
   endfunction

   function automatic pool_req_type random_request(int pct_insert, int pct_read, int pct_age,
                                                   bit wide_steps);
      pool_req_type r;
      int           pick;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0:       r.life = '0;
         1:       r.life = '1;
         2, 3, 4: r.life = LIFE_W'($urandom_range(0, 300));
         default: r.life = LIFE_W'($urandom);
      endcase
      r.age     = NEW_AGE_W'($urandom);
      r.payload = {$urandom, $urandom};
      r.slot    = SLOT_W'($urandom);
      if (pool_count > 0 && $urandom_range(0, 3) != 0)
         r.slot = SLOT_W'($urandom_range(0, pool_count - 1));
      if (!wide_steps) begin
         r.step = STEP_W'($urandom_range(0, 3));
      end else begin
         case ($urandom_range(0, 9))
            0:       r.step = '0;
            1, 2:    r.step = STEP_W'($urandom);
            // land exactly on a live entry's life
            3, 4:    r.step = (pool_count > 0) ?
                              pool_life[$urandom_range(0, pool_count - 1)] : '0;
            default: r.step = STEP_W'($urandom_range(0, 255));
         endcase
      end
      if (pick < pct_insert)
         r.op = OP_INSERT;
      else if (pick < pct_insert + pct_read)
         r.op = OP_READ;
      else if (pick < pct_insert + pct_read + pct_age)
         r.op = OP_AGE;
      else
         r.op = OP_NOP;
      return r;
   endfunction

   task automatic send_item(pool_req_type r, bit known, pool_rsp_type want);
      pool_rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= REQ_TDATA_W'({r.slot, r.step, r.payload, r.age, r.life});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_to_pool(r);
      pending_rsps.insert(pending_rsps.size(), known ? want : predicted);
      items_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_item(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].rsp);

      // fill to capacity, then push inserts against a full pool
      while (pool_count < POOL_DEPTH && items_sent < FILL_LIMIT)
         send_item(random_request(85, 8, 4, 1'b0), 1'b0, NO_RSP);
      repeat (40) send_item(random_request(60, 40, 0, 1'b0), 1'b0, NO_RSP);
      wait_for_drain();

      // churn, opening with a long receiver stall
      hold_off_req = 1'b1;
      while (items_sent < CHURN_END)
         send_item(random_request(40, 35, 15, 1'b1), 1'b0, NO_RSP);
      wait_for_drain();

      gaps_on = 1'b0;
      while (items_sent < TOTAL_ITEMS)
         send_item(random_request(40, 35, 15, 1'b1), 1'b0, NO_RSP);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : rsp_ready_ctl
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      pool_rsp_type got;
      pool_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.accepted   = rsp_tdata[0];
         got.live       = rsp_tdata[RSP_LIVE_LO +: LIVE_W];
         got.slot_valid = rsp_tdata[RSP_VALID_LO];
         got.life       = rsp_tdata[RSP_LIFE_LO +: LIFE_W];
         got.age        = rsp_tdata[RSP_AGE_LO +: AGE_W];
         got.payload    = rsp_tdata[RSP_PAY_LO +: PAYLOAD_W];
         if (pending_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response word with nothing outstanding: %p", $time, got);
         end else begin
            want = pending_rsps.pop_front();
            if (got.accepted !== want.accepted || got.live !== want.live ||
                got.slot_valid !== want.slot_valid || got.life !== want.life ||
                got.age !== want.age || got.payload !== want.payload) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: response word mismatch", $time);
                  $display("   expected %p", want);
                  $display("   actual   %p", got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

endmodule
